// File: rtl/ssan_pkg.sv
// Shared types, constants and the byte classification function for the symbol name sanitizer.
// Used by ssan_core, ssan_outq and symbol_name_sanitizer; depends on nothing else.
`default_nettype none

package ssan_pkg;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_P     = 8'h70;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   // Result queue geometry.
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // One result item.
   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       name_end;
      logic       run_last;
   } result_type;

   // Returns the kept character (+ as p, - as m), or CHAR_NONE for a separator.
   function automatic logic [7:0] map_byte(input logic [7:0] c);
      logic [7:0] m;
      m = CHAR_NONE;
      if ((c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) ||
          (c inside {[8'h30:8'h39]}) || (c == CHAR_UNDER)) begin
         m = c;
      end else if (c == CHAR_PLUS) begin
         m = CHAR_P;
      end else if (c == CHAR_MINUS) begin
         m = CHAR_M;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ssan_core.sv
// Per-byte result generation and the separator/emitted state of the current name.
// Depends on ssan_pkg.
`default_nettype none

module ssan_core
   import ssan_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] in_char,
   input  wire logic       is_last,
   output result_type      res0,
   output result_type      res1,
   output logic [1:0]      res_count
);

   logic       sep_pending_ff, sep_pending_in;
   logic       emitted_any_ff, emitted_any_in;
   logic [7:0] mapped;
   logic       kept;

   assign mapped = map_byte(in_char);
   assign kept   = (mapped != CHAR_NONE);

   always_comb begin
      res0           = '0;
      res1           = '0;
      res_count      = 2'd0;
      sep_pending_in = sep_pending_ff;
      emitted_any_in = emitted_any_ff;
      if (kept) begin
         if (sep_pending_ff && emitted_any_ff) begin
            res0      = '{out_char: CHAR_UNDER, has_char: 1'b1, name_end: 1'b0, run_last: 1'b0};
            res1      = '{out_char: mapped, has_char: 1'b1, name_end: is_last, run_last: 1'b1};
            res_count = 2'd2;
         end else begin
            res0      = '{out_char: mapped, has_char: 1'b1, name_end: is_last, run_last: 1'b1};
            res_count = 2'd1;
         end
         emitted_any_in = 1'b1;
         sep_pending_in = 1'b0;
      end else if (is_last) begin
         // A final separator closes the name; with nothing kept it stands as one underscore.
         if (emitted_any_ff) begin
            res0 = '{out_char: CHAR_NONE, has_char: 1'b0, name_end: 1'b1, run_last: 1'b1};
         end else begin
            res0 = '{out_char: CHAR_UNDER, has_char: 1'b1, name_end: 1'b1, run_last: 1'b1};
         end
         res_count = 2'd1;
      end else if (emitted_any_ff) begin
         sep_pending_in = 1'b1;
      end
      if (is_last) begin
         sep_pending_in = 1'b0;
         emitted_any_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_pending_ff <= 1'b0;
         emitted_any_ff <= 1'b0;
      end else if (step) begin
         sep_pending_ff <= sep_pending_in;
         emitted_any_ff <= emitted_any_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ssan_outq.sv
// Small result queue that takes up to two results per cycle and gives one per cycle while out_ready is high.
// Depends on ssan_pkg.
`default_nettype none

module ssan_outq
   import ssan_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          push_count,
   input  wire result_type          push0,
   input  wire result_type          push1,
   output logic [OQ_CNT_W-1:0]      free_slots,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output result_type               out_data
);

   result_type              mem [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [OQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OQ_CNT_W-1:0]     count_ff, count_in;
   logic [OQ_PTR_W-1:0]     wr_next;
   logic                    pop;

   assign out_valid  = (count_ff != '0);
   assign out_data   = mem[rd_ptr_ff];
   assign free_slots = OQ_CNT_W'(OQ_DEPTH) - count_ff;
   assign pop        = out_valid && out_ready;
   assign wr_next    = wr_ptr_ff + OQ_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OQ_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + OQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + OQ_CNT_W'(push_count) - OQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/symbol_name_sanitizer.sv
// Symbol name sanitizer top level: input register, result generation and result queue.
// Depends on ssan_pkg, ssan_core and ssan_outq.
// Throughput: one byte per cycle while the result queue has room for its results.
// The result queue drains one result per cycle while rsp_tready is high.
// A byte is taken whenever the input register is free or moves on in the same cycle.
// Reset (synchronous, active high) empties both stages and starts a new name.
`default_nettype none

module symbol_name_sanitizer
   import ssan_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // Input byte stream.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,   // is_last
   // Result stream.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic [1:0]      rsp_tuser,   // [0] has_char, [1] run_last
   output logic            rsp_tlast    // name_end
);

   // Input register: holds one byte until the queue has room for all its results.
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_char_ff;
   logic                s1_last_ff;
   logic                advance;
   logic                req_xfer;

   result_type          res0;
   result_type          res1;
   logic [1:0]          res_count;
   logic [1:0]          push_count;
   logic [OQ_CNT_W-1:0] free_slots;
   result_type          q_data;

   // A byte moves on only when every result it causes fits in the queue. The check reads
   // the registered fill level, so rsp_tready never reaches req_tready in the same cycle.
   assign advance    = s1_valid_ff && (free_slots >= OQ_CNT_W'(res_count));
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign push_count = advance ? res_count : 2'd0;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Payload of the input register needs no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // Classification and the name state; state moves only when the byte leaves the register.
   ssan_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_char   (s1_char_ff),
      .is_last   (s1_last_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   // The queue decouples the output handshake from the input side.
   ssan_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .free_slots (free_slots),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (q_data)
   );

   assign rsp_tdata = q_data.out_char;
   assign rsp_tuser = {q_data.run_last, q_data.has_char};
   assign rsp_tlast = q_data.name_end;

   // A result that closes a name is always the last result of its byte.
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("name end result without run_last");

   // A result with no character carries a zero code and only closes a name.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == CHAR_NONE) && rsp_tlast)
      else $error("result without character is malformed");

   // A byte that waits in the input register keeps its value until it moves on.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff))
      else $error("waiting input byte changed");

endmodule

`default_nettype wire
